@@ rtl/core/flow_vector_polar_binning_defines.svh @@
// Assertion macros used by the binning stages of the flow vector binning RTL.
`ifndef FLOW_VECTOR_POLAR_BINNING_DEFINES_SVH
`define FLOW_VECTOR_POLAR_BINNING_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define FVPB_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fvpb: implication check failed");

// next-cycle implication, sampled on clock, off during reset
`define FVPB_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fvpb: next-cycle check failed");

`endif

@@ rtl/core/fvpb_pkg.sv @@
// Package: widths, constants, types and tables of the flow vector binning block.
package fvpb_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 4;
   localparam int POS_W      = COORD_BITS + FRAC_BITS + 1;
   localparam int DELTA_W    = POS_W + 1;
   localparam int ABS_W      = POS_W;
   localparam int SQ_W       = 2 * ABS_W + 1;
   localparam int CNT_W      = 7;
   localparam int MA_W       = 9;
   localparam int BIN_W      = 6;
   localparam int MBSQ_W     = 2 * CNT_W - 1;
   localparam int LHS_W      = SQ_W + MBSQ_W;
   localparam int MAX_BINS   = 64;

   localparam int CORDIC_STEPS = 23;
   localparam int NORM_BIT     = 40;
   localparam int CW           = NORM_BIT + 4;
   localparam int ZW           = 25;
   localparam int MSB_W        = $clog2(ABS_W);
   localparam int SHIFT_W      = $clog2(NORM_BIT + 1);

   localparam int ANG_FRAC = 16;
   localparam int ANG_W    = 25;
   localparam int M_W      = CNT_W + ANG_W - ANG_FRAC;
   localparam int DEG_ONE  = 1 << ANG_FRAC;
   localparam int DEG45    = 45 * DEG_ONE;
   localparam int DEG90    = 90 * DEG_ONE;
   localparam int DEG360   = 360 * DEG_ONE;

   localparam int FRONT_STAGES = 4;
   localparam int BIN_STAGES   = BIN_W + 3;

   typedef enum logic [1:0] {
      REG_ORIENT_BINS = 2'd0,
      REG_MAG_BINS    = 2'd1,
      REG_MAX_ANGLE   = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [CNT_W-1:0]  ob;
      logic [CNT_W-1:0]  mb;
      logic [MBSQ_W-1:0] mb_sq;
      logic [MA_W-1:0]   ma;
   } cfg_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] px;
      logic [COORD_BITS-1:0] py;
      logic [1:0]            base;
      logic                  dy_zero;
      logic                  y_zero;
      logic                  y_eq;
      logic                  inv;
      logic [LHS_W-1:0]      lhs;
   } side_type;

   function automatic logic [CNT_W-1:0] clamp_bins(input logic [CNT_W-1:0] b);
      logic [CNT_W-1:0] r;
      r = b;
      if (b == '0) r = CNT_W'(1);
      else if (b > CNT_W'(MAX_BINS)) r = CNT_W'(MAX_BINS);
      return r;
   endfunction

   function automatic logic signed [ZW-1:0] atan_unit(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0: r = ZW'(2949120);
         1: r = ZW'(1740967);
         2: r = ZW'(919879);
         3: r = ZW'(466945);
         4: r = ZW'(234379);
         5: r = ZW'(117304);
         6: r = ZW'(58666);
         7: r = ZW'(29335);
         8: r = ZW'(14668);
         9: r = ZW'(7334);
         10: r = ZW'(3667);
         11: r = ZW'(1833);
         12: r = ZW'(917);
         13: r = ZW'(458);
         14: r = ZW'(229);
         15: r = ZW'(115);
         16: r = ZW'(57);
         17: r = ZW'(29);
         18: r = ZW'(14);
         19: r = ZW'(7);
         20: r = ZW'(4);
         21: r = ZW'(2);
         22: r = ZW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/fvpb_front.sv @@
// Front stages: deltas, quadrant fold, squares, normalization and scaled length.
module fvpb_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   hold_out,
   input  logic [fvpb_pkg::COORD_BITS-1:0]        prev_x,
   input  logic [fvpb_pkg::COORD_BITS-1:0]        prev_y,
   input  logic signed [fvpb_pkg::POS_W-1:0]      next_x_q4,
   input  logic signed [fvpb_pkg::POS_W-1:0]      next_y_q4,
   input  fvpb_pkg::cfg_type                      cfg,
   output logic                                   out_valid,
   input  logic                                   hold_in,
   output logic signed [fvpb_pkg::CW-1:0]         out_x,
   output logic signed [fvpb_pkg::CW-1:0]         out_y,
   output fvpb_pkg::side_type                     out_side
);
   localparam int NS = fvpb_pkg::FRONT_STAGES;

   logic [NS-1:0] v_ff;
   logic [NS:0]   hold;

   logic [fvpb_pkg::DELTA_W-1:0] dx, dy, ndx, ndy;
   logic                         dxn, dxz, dxp, dyn, dyz, dyp;
   logic [1:0]                   base;

   logic [fvpb_pkg::COORD_BITS-1:0] px1_ff, py1_ff, px2_ff, py2_ff, px3_ff, py3_ff;
   logic [fvpb_pkg::ABS_W-1:0]      ax1_ff, ay1_ff;
   logic [1:0]                      base1_ff, base2_ff, base3_ff;
   logic                            dyz1_ff, dyz2_ff, dyz3_ff;

   logic [fvpb_pkg::ABS_W-1:0]      qx, qy;
   logic [fvpb_pkg::ABS_W-1:0]      p2_ff, q2_ff;
   logic [2*fvpb_pkg::ABS_W-1:0]    sqx2_ff, sqy2_ff;
   logic                            yz2_ff, yeq2_ff, inv2_ff, yz3_ff, yeq3_ff, inv3_ff;

   logic [fvpb_pkg::MSB_W-1:0]      msb;
   logic [fvpb_pkg::SHIFT_W-1:0]    sh;
   logic signed [fvpb_pkg::CW-1:0]  x3_ff, y3_ff, x4_ff, y4_ff;
   logic [fvpb_pkg::SQ_W-1:0]       s3_ff;
   fvpb_pkg::side_type              side4_ff;

   always_comb begin
      hold[NS] = hold_in;
      for (int i = NS - 1; i >= 0; i--) begin
         hold[i] = v_ff[i] && hold[i+1];
      end
   end

   assign hold_out  = hold[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (!hold[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            if (!hold[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // stage 1: deltas and quadrant
   always_comb begin
      dx  = {next_x_q4[fvpb_pkg::POS_W-1], next_x_q4}
            - (fvpb_pkg::DELTA_W'(prev_x) << fvpb_pkg::FRAC_BITS);
      dy  = {next_y_q4[fvpb_pkg::POS_W-1], next_y_q4}
            - (fvpb_pkg::DELTA_W'(prev_y) << fvpb_pkg::FRAC_BITS);
      ndx = -dx;
      ndy = -dy;
      dxn = dx[fvpb_pkg::DELTA_W-1];
      dyn = dy[fvpb_pkg::DELTA_W-1];
      dxz = (dx == '0);
      dyz = (dy == '0);
      dxp = !dxn && !dxz;
      dyp = !dyn && !dyz;
      if (dxp && !dyn)      base = 2'd0;
      else if (!dxp && dyp) base = 2'd1;
      else if (dxn && !dyp) base = 2'd2;
      else                  base = 2'd3;
   end

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         px1_ff   <= prev_x;
         py1_ff   <= prev_y;
         ax1_ff   <= dxn ? ndx[fvpb_pkg::ABS_W-1:0] : dx[fvpb_pkg::ABS_W-1:0];
         ay1_ff   <= dyn ? ndy[fvpb_pkg::ABS_W-1:0] : dy[fvpb_pkg::ABS_W-1:0];
         base1_ff <= base;
         dyz1_ff  <= dyz;
      end
   end

   // stage 2: fold to ratio form, squares
   assign qx = base1_ff[0] ? ay1_ff : ax1_ff;
   assign qy = base1_ff[0] ? ax1_ff : ay1_ff;

   always_ff @(posedge clock) begin
      if (!hold[1]) begin
         px2_ff   <= px1_ff;
         py2_ff   <= py1_ff;
         base2_ff <= base1_ff;
         dyz2_ff  <= dyz1_ff;
         yz2_ff   <= (qy == '0);
         yeq2_ff  <= (qy == qx);
         inv2_ff  <= (qy > qx);
         p2_ff    <= (qy > qx) ? qx : qy;
         q2_ff    <= (qy > qx) ? qy : qx;
         sqx2_ff  <= (2*fvpb_pkg::ABS_W)'(ax1_ff) * (2*fvpb_pkg::ABS_W)'(ax1_ff);
         sqy2_ff  <= (2*fvpb_pkg::ABS_W)'(ay1_ff) * (2*fvpb_pkg::ABS_W)'(ay1_ff);
      end
   end

   // stage 3: normalize larger component to the CORDIC range, sum of squares
   always_comb begin
      msb = '0;
      for (int i = 0; i < fvpb_pkg::ABS_W; i++) begin
         if (q2_ff[i]) msb = fvpb_pkg::MSB_W'(i);
      end
      sh = fvpb_pkg::SHIFT_W'(fvpb_pkg::NORM_BIT) - fvpb_pkg::SHIFT_W'(msb);
   end

   always_ff @(posedge clock) begin
      if (!hold[2]) begin
         px3_ff   <= px2_ff;
         py3_ff   <= py2_ff;
         base3_ff <= base2_ff;
         dyz3_ff  <= dyz2_ff;
         yz3_ff   <= yz2_ff;
         yeq3_ff  <= yeq2_ff;
         inv3_ff  <= inv2_ff;
         x3_ff    <= fvpb_pkg::CW'(q2_ff) << sh;
         y3_ff    <= fvpb_pkg::CW'(p2_ff) << sh;
         s3_ff    <= fvpb_pkg::SQ_W'(sqx2_ff) + fvpb_pkg::SQ_W'(sqy2_ff);
      end
   end

   // stage 4: scale length by bin count squared
   always_ff @(posedge clock) begin
      if (!hold[3]) begin
         x4_ff            <= x3_ff;
         y4_ff            <= y3_ff;
         side4_ff.px      <= px3_ff;
         side4_ff.py      <= py3_ff;
         side4_ff.base    <= base3_ff;
         side4_ff.dy_zero <= dyz3_ff;
         side4_ff.y_zero  <= yz3_ff;
         side4_ff.y_eq    <= yeq3_ff;
         side4_ff.inv     <= inv3_ff;
         side4_ff.lhs     <= fvpb_pkg::LHS_W'(cfg.mb_sq) * fvpb_pkg::LHS_W'(s3_ff);
      end
   end

   assign out_x    = x4_ff;
   assign out_y    = y4_ff;
   assign out_side = side4_ff;

endmodule

@@ rtl/core/fvpb_cordic.sv @@
// CORDIC vectoring pipeline: one rotation step per register stage.
module fvpb_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               hold_out,
   input  logic signed [fvpb_pkg::CW-1:0]     in_x,
   input  logic signed [fvpb_pkg::CW-1:0]     in_y,
   input  fvpb_pkg::side_type                 in_side,
   output logic                               out_valid,
   input  logic                               hold_in,
   output logic signed [fvpb_pkg::ZW-1:0]     out_z,
   output fvpb_pkg::side_type                 out_side
);
   localparam int NS = fvpb_pkg::CORDIC_STEPS;

   logic [NS-1:0] v_ff;
   logic [NS:0]   hold;

   logic signed [fvpb_pkg::CW-1:0] x_ff [NS-1];
   logic signed [fvpb_pkg::CW-1:0] y_ff [NS-1];
   logic signed [fvpb_pkg::ZW-1:0] z_ff [NS];
   fvpb_pkg::side_type             side_ff [NS];

   always_comb begin
      hold[NS] = hold_in;
      for (int i = NS - 1; i >= 0; i--) begin
         hold[i] = v_ff[i] && hold[i+1];
      end
   end

   assign hold_out  = hold[0];
   assign out_valid = v_ff[NS-1];
   assign out_z     = z_ff[NS-1];
   assign out_side  = side_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (!hold[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            if (!hold[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_step
      logic signed [fvpb_pkg::CW-1:0] xi, yi;
      logic signed [fvpb_pkg::ZW-1:0] zi;
      fvpb_pkg::side_type             si;

      if (i == 0) begin : g_first
         assign xi = in_x;
         assign yi = in_y;
         assign zi = '0;
         assign si = in_side;
      end else begin : g_next
         assign xi = x_ff[i-1];
         assign yi = y_ff[i-1];
         assign zi = z_ff[i-1];
         assign si = side_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (!hold[i]) begin
            side_ff[i] <= si;
            if (!yi[fvpb_pkg::CW-1]) z_ff[i] <= zi + fvpb_pkg::atan_unit(i);
            else                     z_ff[i] <= zi - fvpb_pkg::atan_unit(i);
         end
      end

      if (i < NS - 1) begin : g_rot
         logic signed [fvpb_pkg::CW-1:0] xs, ys;
         assign xs = xi >>> i;
         assign ys = yi >>> i;
         always_ff @(posedge clock) begin
            if (!hold[i]) begin
               if (!yi[fvpb_pkg::CW-1]) begin
                  x_ff[i] <= xi + ys;
                  y_ff[i] <= yi - xs;
               end else begin
                  x_ff[i] <= xi - ys;
                  y_ff[i] <= yi + xs;
               end
            end
         end
      end
   end

endmodule

@@ rtl/core/fvpb_bins.sv @@
// Back stages: full-turn angle, orientation divide and magnitude bin search.
`include "flow_vector_polar_binning_defines.svh"

module fvpb_bins (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                hold_out,
   input  logic signed [fvpb_pkg::ZW-1:0]      in_z,
   input  fvpb_pkg::side_type                  in_side,
   input  fvpb_pkg::cfg_type                   cfg,
   output logic                                out_valid,
   input  logic                                hold_in,
   output logic [fvpb_pkg::COORD_BITS-1:0]     out_cell_x,
   output logic [fvpb_pkg::COORD_BITS-1:0]     out_cell_y,
   output logic [fvpb_pkg::BIN_W-1:0]          out_orientation_bin,
   output logic [fvpb_pkg::BIN_W-1:0]          out_magnitude_bin
);
   localparam int NS = fvpb_pkg::BIN_STAGES;
   localparam int BW = fvpb_pkg::BIN_W;
   localparam int AW = fvpb_pkg::ANG_W;
   localparam int PW = fvpb_pkg::CNT_W + fvpb_pkg::ANG_W;

   typedef struct packed {
      logic [fvpb_pkg::COORD_BITS-1:0] px;
      logic [fvpb_pkg::COORD_BITS-1:0] py;
      logic                            dy_zero;
      logic [fvpb_pkg::LHS_W-1:0]      lhs;
   } bside_type;

   logic [NS-1:0] v_ff;
   logic [NS:0]   hold;

   logic signed [fvpb_pkg::ZW-1:0] zc;
   logic [AW-1:0]                  a;
   logic [AW:0]                    tot;
   logic [AW-1:0]                  ang0_ff;
   bside_type                      bs0_ff, bs1_ff;
   logic [PW-1:0]                  prod;
   logic [fvpb_pkg::M_W-1:0]       m1_ff;

   logic [fvpb_pkg::M_W-1:0] rem_ff [BW];
   logic [BW-1:0]            quo_ff [BW];
   logic                     ovf_ff [BW];
   logic [BW-1:0]            k_ff   [BW];
   bside_type                bs_ff  [BW];

   logic [BW-1:0]                   qf;
   logic [fvpb_pkg::CNT_W-1:0]      lim;
   logic [fvpb_pkg::COORD_BITS-1:0] cx_ff, cy_ff;
   logic [BW-1:0]                   ob_ff, mbin_ff;

   always_comb begin
      hold[NS] = hold_in;
      for (int i = NS - 1; i >= 0; i--) begin
         hold[i] = v_ff[i] && hold[i+1];
      end
   end

   assign hold_out  = hold[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (!hold[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            if (!hold[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // stage 0: place the partial angle in its quadrant
   always_comb begin
      zc = in_z;
      if (in_z < 0) zc = '0;
      else if (in_z > fvpb_pkg::ZW'(fvpb_pkg::DEG45)) zc = fvpb_pkg::ZW'(fvpb_pkg::DEG45);
      if (in_side.y_zero)     a = '0;
      else if (in_side.y_eq)  a = AW'(fvpb_pkg::DEG45);
      else if (in_side.inv)   a = AW'(fvpb_pkg::DEG90) - AW'(zc);
      else                    a = AW'(zc);
      tot = (AW+1)'(a) + (AW+1)'(in_side.base) * (AW+1)'(fvpb_pkg::DEG90);
      if (tot > (AW+1)'(fvpb_pkg::DEG360 - 1)) tot = (AW+1)'(fvpb_pkg::DEG360 - 1);
   end

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         ang0_ff        <= tot[AW-1:0];
         bs0_ff.px      <= in_side.px;
         bs0_ff.py      <= in_side.py;
         bs0_ff.dy_zero <= in_side.dy_zero;
         bs0_ff.lhs     <= in_side.lhs;
      end
   end

   // stage 1: scale angle by bin count, drop the degree fraction
   assign prod = PW'(cfg.ob) * PW'(ang0_ff);

   always_ff @(posedge clock) begin
      if (!hold[1]) begin
         m1_ff  <= prod[PW-1:fvpb_pkg::ANG_FRAC];
         bs1_ff <= bs0_ff;
      end
   end

   // one quotient bit and one magnitude bit per stage
   for (genvar j = 0; j < BW; j++) begin : g_div
      localparam int B = BW - 1 - j;
      logic [fvpb_pkg::M_W-1:0]   rem_i, trial;
      logic [BW-1:0]              quo_i, k_i, c;
      logic                       ovf_i, fit;
      logic [2*BW-1:0]            cc;
      logic [fvpb_pkg::LHS_W-1:0] t;
      bside_type                  bs_i;

      if (j == 0) begin : g_first
         assign rem_i = m1_ff;
         assign quo_i = '0;
         assign ovf_i = (m1_ff >= (fvpb_pkg::M_W'(cfg.ma) << BW));
         assign k_i   = '0;
         assign bs_i  = bs1_ff;
      end else begin : g_next
         assign rem_i = rem_ff[j-1];
         assign quo_i = quo_ff[j-1];
         assign ovf_i = ovf_ff[j-1];
         assign k_i   = k_ff[j-1];
         assign bs_i  = bs_ff[j-1];
      end

      assign trial = fvpb_pkg::M_W'(cfg.ma) << B;
      assign c     = k_i | (BW'(1) << B);
      assign cc    = (2*BW)'(c) * (2*BW)'(c);
      assign t     = (fvpb_pkg::LHS_W'(cc) * fvpb_pkg::LHS_W'(9)) << (2*fvpb_pkg::FRAC_BITS);
      assign fit   = ({1'b0, c} <= (cfg.mb - fvpb_pkg::CNT_W'(1))) && (t <= bs_i.lhs);

      always_ff @(posedge clock) begin
         if (!hold[j+2]) begin
            ovf_ff[j] <= ovf_i;
            bs_ff[j]  <= bs_i;
            k_ff[j]   <= fit ? c : k_i;
            if (rem_i >= trial) begin
               rem_ff[j] <= rem_i - trial;
               quo_ff[j] <= quo_i | (BW'(1) << B);
            end else begin
               rem_ff[j] <= rem_i;
               quo_ff[j] <= quo_i;
            end
         end
      end
   end

   // output stage: orientation bin zero when the vertical delta is zero, else saturate to last bin
   always_comb begin
      qf  = ovf_ff[BW-1] ? '1 : quo_ff[BW-1];
      lim = cfg.ob - fvpb_pkg::CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (!hold[NS-1]) begin
         cx_ff   <= bs_ff[BW-1].px;
         cy_ff   <= bs_ff[BW-1].py;
         mbin_ff <= k_ff[BW-1];
         if (bs_ff[BW-1].dy_zero)     ob_ff <= '0;
         else if ({1'b0, qf} > lim)   ob_ff <= lim[BW-1:0];
         else                         ob_ff <= qf;
      end
   end

   assign out_cell_x          = cx_ff;
   assign out_cell_y          = cy_ff;
   assign out_orientation_bin = ob_ff;
   assign out_magnitude_bin   = mbin_ff;

   `FVPB_ASSERT_IMP(a_orient_in_range, out_valid, ({1'b0, ob_ff} < cfg.ob))
   `FVPB_ASSERT_IMP(a_mag_in_range, out_valid, ({1'b0, mbin_ff} < cfg.mb))
   `FVPB_ASSERT_IMP(a_div_remainder, (v_ff[BW+1] && !ovf_ff[BW-1]), (rem_ff[BW-1] < fvpb_pkg::M_W'(cfg.ma)))
   `FVPB_ASSERT_NXT(a_entry_loaded, (in_valid && !hold[0]), v_ff[0])

endmodule

@@ rtl/core/flow_vector_polar_binning.sv @@
// Top level of the flow vector polar binning block: register file and stage chain.
// Takes one tracked point per clock while req_stall is low (start pixel, Q.4 end position)
// and returns its start cell, an orientation bin and a magnitude bin. A beat goes
// through 36 register stages (4 front stages, 23 CORDIC rotation stages, 9 binning
// stages) at a sustained rate of one beat per cycle while nothing stalls. A stalled
// result holds only the stages behind it that are full, so empty stages keep taking
// beats. The user must write registers (index: orientation bin count, magnitude bin
// count, max angle in degrees) only while idle; the block does not enforce it.
module flow_vector_polar_binning (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fvpb_pkg::COORD_BITS-1:0]     req_prev_x,
   input  logic [fvpb_pkg::COORD_BITS-1:0]     req_prev_y,
   input  logic signed [fvpb_pkg::POS_W-1:0]   req_next_x_q4,
   input  logic signed [fvpb_pkg::POS_W-1:0]   req_next_y_q4,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fvpb_pkg::COORD_BITS-1:0]     rsp_cell_x,
   output logic [fvpb_pkg::COORD_BITS-1:0]     rsp_cell_y,
   output logic [fvpb_pkg::BIN_W-1:0]          rsp_orientation_bin,
   output logic [fvpb_pkg::BIN_W-1:0]          rsp_magnitude_bin,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [fvpb_pkg::MA_W-1:0]           csr_data
);
   fvpb_pkg::cfg_type              cfg_ff;
   logic [fvpb_pkg::CNT_W-1:0]     bins_in;

   logic                           f_valid, f_hold, c_valid, c_hold;
   logic signed [fvpb_pkg::CW-1:0] f_x, f_y;
   fvpb_pkg::side_type             f_side, c_side;
   logic signed [fvpb_pkg::ZW-1:0] c_z;

   assign csr_ready = 1'b1;
   assign bins_in   = fvpb_pkg::clamp_bins(csr_data[fvpb_pkg::CNT_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ob    <= fvpb_pkg::CNT_W'(8);
         cfg_ff.mb    <= fvpb_pkg::CNT_W'(8);
         cfg_ff.mb_sq <= fvpb_pkg::MBSQ_W'(64);
         cfg_ff.ma    <= fvpb_pkg::MA_W'(360);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fvpb_pkg::REG_ORIENT_BINS: begin
               cfg_ff.ob <= bins_in;
            end
            fvpb_pkg::REG_MAG_BINS: begin
               cfg_ff.mb    <= bins_in;
               cfg_ff.mb_sq <= fvpb_pkg::MBSQ_W'(bins_in) * fvpb_pkg::MBSQ_W'(bins_in);
            end
            fvpb_pkg::REG_MAX_ANGLE: begin
               cfg_ff.ma <= (csr_data == '0) ? fvpb_pkg::MA_W'(1) : csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   fvpb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .hold_out  (req_stall),
      .prev_x    (req_prev_x),
      .prev_y    (req_prev_y),
      .next_x_q4 (req_next_x_q4),
      .next_y_q4 (req_next_y_q4),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .hold_in   (f_hold),
      .out_x     (f_x),
      .out_y     (f_y),
      .out_side  (f_side)
   );

   fvpb_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .hold_out  (f_hold),
      .in_x      (f_x),
      .in_y      (f_y),
      .in_side   (f_side),
      .out_valid (c_valid),
      .hold_in   (c_hold),
      .out_z     (c_z),
      .out_side  (c_side)
   );

   fvpb_bins u_bins (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (c_valid),
      .hold_out            (c_hold),
      .in_z                (c_z),
      .in_side             (c_side),
      .cfg                 (cfg_ff),
      .out_valid           (rsp_valid),
      .hold_in             (rsp_stall),
      .out_cell_x          (rsp_cell_x),
      .out_cell_y          (rsp_cell_y),
      .out_orientation_bin (rsp_orientation_bin),
      .out_magnitude_bin   (rsp_magnitude_bin)
   );

endmodule

@@ sim/flow_vector_polar_binning_tb.sv @@
// Testbench for flow_vector_polar_binning: directed table, then random beats checked against a predictor.
module flow_vector_polar_binning_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int LATENCY = 40;
   localparam longint CYCLE_LIMIT = 1000000;
   localparam longint DEG_Q16 = 65536;
   localparam longint ARCTAN_Q16 [23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

   typedef struct {
      logic [11:0] cell_x;
      logic [11:0] cell_y;
      logic [5:0]  orient;
      logic [5:0]  mag;
   } bins_type;

   typedef struct {
      int px; int py; int nx; int ny;
      bit typed; int orient; int mag;
   } vector_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [11:0] req_prev_x = 0;
   logic [11:0] req_prev_y = 0;
   logic signed [16:0] req_next_x_q4 = 0;
   logic signed [16:0] req_next_y_q4 = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [11:0] rsp_cell_x;
   logic [11:0] rsp_cell_y;
   logic [5:0] rsp_orientation_bin;
   logic [5:0] rsp_magnitude_bin;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = 0;
   logic [8:0] csr_data = 0;

   logic [6:0] orient_bins_q = 8;
   logic [6:0] mag_bins_q = 8;
   logic [8:0] max_angle_q = 360;

   bins_type pending_bins[$];
   int mismatches = 0;
   longint cycles = 0;
   bit quiet = 0;
   bit long_hold = 0;

   flow_vector_polar_binning u_dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic longint arctan_q16(longint p, longint q);
      longint x, y, z, xs, ys;
      z = 0;
      while (q < (64'sd1 <<< 40)) begin
         p = p * 2;
         q = q * 2;
      end
      x = q;
      y = p;
      for (int i = 0; i < 23; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + ARCTAN_Q16[i];
         end else begin
            x = x - ys; y = y + xs; z = z - ARCTAN_Q16[i];
         end
      end
      if (z < 0) z = 0;
      if (z > 45 * DEG_Q16) z = 45 * DEG_Q16;
      return z;
   endfunction

   function automatic longint direction_q16(longint dx, longint dy);
      longint x, y, base, a;
      if (dx > 0 && dy >= 0) begin
         base = 0; x = dx; y = dy;
      end else if (dx <= 0 && dy > 0) begin
         base = 90; x = dy; y = -dx;
      end else if (dx < 0 && dy <= 0) begin
         base = 180; x = -dx; y = -dy;
      end else begin
         base = 270; x = -dy; y = dx;
      end
      if (y == 0) a = 0;
      else if (y == x) a = 45 * DEG_Q16;
      else if (y < x) a = arctan_q16(y, x);
      else a = 90 * DEG_Q16 - arctan_q16(x, y);
      a = a + base * DEG_Q16;
      if (a < 0) a = 0;
      if (a > 360 * DEG_Q16 - 1) a = 360 * DEG_Q16 - 1;
      return a;
   endfunction

   function automatic longint sat_bins(logic [6:0] b);
      if (b == 0) return 1;
      if (b > 64) return 64;
      return b;
   endfunction

   function automatic bins_type polar_bins(int px, int py, int nx, int ny);
      bins_type r;
      longint dx, dy, ob, mb, ma, ob_bin, k, len_sq;
      dx = nx - px * 16;
      dy = ny - py * 16;
      ob = sat_bins(orient_bins_q);
      mb = sat_bins(mag_bins_q);
      ma = (max_angle_q == 0) ? 1 : max_angle_q;
      ob_bin = 0;
      if (dy != 0) begin
         ob_bin = (ob * direction_q16(dx, dy)) / (ma * DEG_Q16);
         if (ob_bin > ob - 1) ob_bin = ob - 1;
      end
      len_sq = mb * mb * (dx * dx + dy * dy);
      for (k = mb - 1; k > 0; k--)
         if (9 * 256 * k * k <= len_sq) break;
      r.cell_x = px[11:0];
      r.cell_y = py[11:0];
      r.orient = ob_bin[5:0];
      r.mag = k[5:0];
      return r;
   endfunction

   task automatic send_vector(vector_row_type v);
      bins_type e;
      req_valid <= 1;
      req_prev_x <= v.px[11:0];
      req_prev_y <= v.py[11:0];
      req_next_x_q4 <= v.nx[16:0];
      req_next_y_q4 <= v.ny[16:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = polar_bins(v.px, v.py, v.nx, v.ny);
      if (v.typed) begin
         e.orient = v.orient[5:0];
         e.mag = v.mag[5:0];
      end
      pending_bins = {pending_bins, e};
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [8:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         fvpb_pkg::REG_ORIENT_BINS: orient_bins_q = value[6:0];
         fvpb_pkg::REG_MAG_BINS:    mag_bins_q = value[6:0];
         fvpb_pkg::REG_MAX_ANGLE:   max_angle_q = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic vector_row_type random_vector();
      vector_row_type v;
      v.typed = 0;
      v.px = $urandom_range(0, 4095);
      v.py = $urandom_range(0, 4095);
      if ($urandom_range(0, 9) < 7) begin
         v.nx = v.px * 16 + $urandom_range(0, 128) - 64;
         v.ny = v.py * 16 + $urandom_range(0, 128) - 64;
         if ($urandom_range(0, 5) == 0) v.ny = v.py * 16;
         if ($urandom_range(0, 7) == 0) v.nx = v.px * 16;
         if (v.nx < -32768) v.nx = -32768;
         if (v.ny < -32768) v.ny = -32768;
         if (v.nx > 65535) v.nx = 65535;
         if (v.ny > 65535) v.ny = 65535;
      end else begin
         v.nx = $urandom_range(0, 98303) - 32768;
         v.ny = $urandom_range(0, 98303) - 32768;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      bins_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bins.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat cell=(%0d,%0d)", rsp_cell_x, rsp_cell_y);
         end else begin
            e = pending_bins.pop_front();
            if (e.cell_x !== rsp_cell_x || e.cell_y !== rsp_cell_y ||
                e.orient !== rsp_orientation_bin || e.mag !== rsp_magnitude_bin) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                           e.cell_x, e.cell_y, e.orient, e.mag, rsp_cell_x, rsp_cell_y,
                           rsp_orientation_bin, rsp_magnitude_bin);
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            long_hold = 0;
            rsp_stall <= 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   initial begin
      vector_row_type directed [12];
      int settings [8][3];
      directed = '{
         '{0, 0, 0, 0, 1, 0, 0},
         '{100, 5, 0, 80, 1, 0, 7},
         '{4095, 4095, 65535, 65535, 1, 1, 3},
         '{0, 0, -32768, 0, 1, 0, 7},
         '{4095, 4095, -32768, -32768, 0, 0, 0},
         '{0, 0, 65535, -32768, 0, 0, 0},
         '{10, 10, 160, 176, 0, 0, 0},
         '{10, 10, 144, 160, 0, 0, 0},
         '{10, 10, 160, 144, 0, 0, 0},
         '{10, 10, 176, 160, 0, 0, 0},
         '{2048, 1, 32768, 0, 0, 0, 0},
         '{1, 2048, 0, 32800, 0, 0, 0}};
      settings = '{'{8, 8, 360}, '{1, 1, 1}, '{64, 64, 360}, '{0, 0, 0},
                   '{127, 127, 511}, '{13, 5, 90}, '{3, 64, 45}, '{64, 1, 360}};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_vector(directed[i]);
      for (int p = 0; p < 8; p++) begin
         drain();
         write_csr(fvpb_pkg::REG_ORIENT_BINS, 9'(settings[p][0]));
         write_csr(fvpb_pkg::REG_MAG_BINS, 9'(settings[p][1]));
         write_csr(fvpb_pkg::REG_MAX_ANGLE, 9'(settings[p][2]));
         write_csr(REG_UNUSED, 9'($urandom_range(0, 511)));
         if (p == 2) long_hold = 1;
         if (p == 7) quiet = 1;
         repeat (210) send_vector(random_vector());
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
